// ===== rtl/vpa_pkg.sv =====
// Shared types, constants and codes of the variable partition allocator.
package vpa_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 16;
	localparam logic [15:0] TOTAL_KB_RST = 16'd1024;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE = 3'd1;
	localparam logic [2:0] ST_NO_FIT   = 3'd2;
	localparam logic [2:0] ST_NO_PID   = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,     // latch the request, start a scan
		OP_SCAN,     // look at one entry
		OP_SPLIT,    // shift one entry up or write the split
		OP_MARK,     // clear owner of one matching entry
		OP_MERGE,    // merge check / shift down one entry
		OP_STAT,     // add one entry into the statistics
		OP_STAT_CLR  // clear statistics and index before a merge or stat pass
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic scan_done;   // index reached entry count
		logic sel_found;   // a partition was chosen
		logic need_split;  // chosen partition is larger than request
		logic table_full;  // entry count is at the maximum
		logic bad_size;    // size zero or above total
		logic pid_found;   // at least one partition was released
		logic shift_done;  // shift or merge pass finished
	} status_t;

endpackage

// ===== rtl/variable_partition_allocator_core.sv =====
// Sequence: an allocate checks the size, scans the table, shifts entries up for a split and
// commits, then runs the statistics pass; a free marks matching entries, merges free neighbours
// and runs the statistics pass. Throughput: one request at a time; a new request is not taken
// until the result has been accepted at the output. The scan, shift and statistics passes step
// one entry per cycle.
// Reset: arst_n clears to one free partition of 1024 KB; a cfg_we write clears to one free partition of cfg_wdata KB.
module variable_partition_allocator_core #(
	parameter int unsigned MAX_ENTRIES = vpa_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] pid,
	input  logic [15:0] size_kb,
	input  logic [1:0]  fit_mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] address,
	output logic [15:0] used_kb,
	output logic [15:0] free_kb,
	output logic [4:0]  entry_total,
	output logic [4:0]  free_fragments
);

	vpa_pkg::cmd_t    cmd;
	vpa_pkg::status_t stat;
	logic [15:0]      dp_addr;
	logic             addr_ok;

	vpa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.stat       (stat),
		.cmd        (cmd),
		.res_status (status),
		.res_addr_ok(addr_ok)
	);

	vpa_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.kind          (kind),
		.pid           (pid),
		.size_kb       (size_kb),
		.fit_mode      (fit_mode),
		.cmd           (cmd),
		.stat          (stat),
		.address       (dp_addr),
		.used_kb       (used_kb),
		.free_kb       (free_kb),
		.entry_total   (entry_total),
		.free_fragments(free_fragments)
	);

	assign address = addr_ok ? dp_addr : 16'd0;

endmodule

// ===== rtl/vpa_datapath.sv =====
// Partition table, scan index, selection and statistics registers.
module vpa_datapath #(
	parameter int unsigned MAX_ENTRIES = vpa_pkg::MAX_ENTRIES_DEF,
	localparam int unsigned IW = $clog2(MAX_ENTRIES),
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            kind,
	input  logic [15:0]     pid,
	input  logic [15:0]     size_kb,
	input  logic [1:0]      fit_mode,
	input  vpa_pkg::cmd_t   cmd,
	output vpa_pkg::status_t stat,
	output logic [15:0]     address,
	output logic [15:0]     used_kb,
	output logic [15:0]     free_kb,
	output logic [4:0]      entry_total,
	output logic [4:0]      free_fragments
);

	logic [15:0] start_q [MAX_ENTRIES];
	logic [15:0] size_q  [MAX_ENTRIES];
	logic [15:0] owner_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] occ_q;

	logic [15:0] total_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] sel_q;
	logic          found_q;
	logic          freed_q;
	logic [15:0]   best_q;
	logic [15:0]   pid_q, req_q;
	logic [1:0]    mode_q;
	logic [15:0]   used_q, freek_q;
	logic [CW-1:0] frags_q;

	logic [IW-1:0] ix;
	logic [IW-1:0] ixm1;
	logic [IW-1:0] ixp1;
	logic [15:0]   diff;
	logic          fits;
	logic          take;
	logic          last_idx;
	logic          need_split;
	logic          split_last;

	assign ix   = idx_q[IW-1:0];
	assign ixm1 = ix - 1'b1;
	assign ixp1 = ix + 1'b1;
	assign diff = size_q[ix] - req_q;
	assign fits = !occ_q[ix] && (size_q[ix] >= req_q);
	assign last_idx = (idx_q + 1'b1 >= count_q);
	assign need_split = (size_q[sel_q] != req_q);
	// An exact fit commits at once; a split shifts down to sel+1 first.
	assign split_last = !need_split || (idx_q <= CW'(sel_q) + 1'b1);

	always_comb begin
		take = 1'b0;
		if (fits) begin
			unique case (mode_q)
				vpa_pkg::MODE_FIRST: take = !found_q;
				vpa_pkg::MODE_BEST:  take = !found_q || (diff < best_q);
				vpa_pkg::MODE_WORST: take = !found_q || (size_q[ix] > best_q);
				default:             take = 1'b0;
			endcase
		end
	end

	assign stat.scan_done  = (idx_q >= count_q);
	assign stat.sel_found  = found_q;
	assign stat.need_split = need_split;
	assign stat.table_full = (count_q >= CW'(MAX_ENTRIES));
	assign stat.bad_size   = (req_q == 16'd0) || (req_q > total_q);
	assign stat.pid_found  = freed_q;
	// Split shift runs from the top down to sel+1; merge pass ends at the last pair.
	assign stat.shift_done = (cmd.op == vpa_pkg::OP_SPLIT) ? split_last : last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= vpa_pkg::TOTAL_KB_RST;
			count_q <= CW'(1);
			occ_q   <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			freed_q <= 1'b0;
			start_q[0] <= '0;
			size_q[0]  <= vpa_pkg::TOTAL_KB_RST;
		end else if (cfg_we) begin
			total_q    <= cfg_wdata;
			count_q    <= CW'(1);
			occ_q      <= '0;
			start_q[0] <= '0;
			size_q[0]  <= cfg_wdata;
		end else begin
			unique case (cmd.op)
				vpa_pkg::OP_LOAD: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					freed_q <= 1'b0;
				end
				vpa_pkg::OP_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (take) begin
						found_q <= 1'b1;
						sel_q   <= ix;
						best_q  <= (mode_q == vpa_pkg::MODE_BEST) ? diff : size_q[ix];
						if (mode_q == vpa_pkg::MODE_FIRST)
							idx_q <= count_q;
					end
				end
				vpa_pkg::OP_SPLIT: begin
					if (!split_last) begin
						start_q[ix] <= start_q[ixm1];
						size_q[ix]  <= size_q[ixm1];
						owner_q[ix] <= owner_q[ixm1];
						occ_q[ix]   <= occ_q[ixm1];
						idx_q       <= idx_q - 1'b1;
					end else if (need_split) begin
						start_q[ix] <= start_q[sel_q] + req_q;
						size_q[ix]  <= size_q[sel_q] - req_q;
						owner_q[ix] <= '0;
						occ_q[ix]   <= 1'b0;
						count_q     <= count_q + 1'b1;
					end
				end
				vpa_pkg::OP_MARK: begin
					idx_q <= idx_q + 1'b1;
					if (occ_q[ix] && owner_q[ix] == pid_q) begin
						occ_q[ix]   <= 1'b0;
						owner_q[ix] <= '0;
						freed_q     <= 1'b1;
					end
				end
				vpa_pkg::OP_MERGE: begin
					// Merge entry ix+1 into ix and shift the entries above it down by one
					// in the same cycle.
					if (!last_idx) begin
						if (!occ_q[ix] && !occ_q[ixp1]) begin
							size_q[ix] <= size_q[ix] + size_q[ixp1];
							for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
								if (j > int'(ix) && CW'(j) + 1'b1 < count_q) begin
									start_q[j] <= start_q[j+1];
									size_q[j]  <= size_q[j+1];
									owner_q[j] <= owner_q[j+1];
									occ_q[j]   <= occ_q[j+1];
								end
							end
							count_q <= count_q - 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				vpa_pkg::OP_STAT_CLR: begin
					idx_q   <= '0;
				end
				vpa_pkg::OP_STAT: begin
					idx_q <= idx_q + 1'b1;
				end
				default: begin
					if (cmd.op == vpa_pkg::OP_NONE && kind == vpa_pkg::KIND_ALLOC) begin
						idx_q <= idx_q;
					end
				end
			endcase
			// Commit the allocation on the split command's final write.
			if (cmd.op == vpa_pkg::OP_SPLIT && split_last) begin
				size_q[sel_q]  <= req_q;
				occ_q[sel_q]   <= 1'b1;
				owner_q[sel_q] <= pid_q;
			end
		end
	end

	// Request fields and statistics need no reset.
	always_ff @(posedge clk) begin
		if (cmd.op == vpa_pkg::OP_LOAD) begin
			pid_q  <= pid;
			req_q  <= size_kb;
			mode_q <= fit_mode;
		end
		if (cmd.op == vpa_pkg::OP_STAT_CLR) begin
			used_q  <= '0;
			freek_q <= '0;
			frags_q <= '0;
		end else if (cmd.op == vpa_pkg::OP_STAT && idx_q < count_q) begin
			if (occ_q[ix]) begin
				used_q <= used_q + size_q[ix];
			end else begin
				freek_q <= freek_q + size_q[ix];
				frags_q <= frags_q + 1'b1;
			end
		end
	end

	assign address        = start_q[sel_q];
	assign used_kb        = used_q;
	assign free_kb        = freek_q;
	assign entry_total    = 5'(count_q);
	assign free_fragments = 5'(frags_q);

endmodule

// ===== rtl/vpa_ctrl.sv =====
// Controller state machine sequencing each request through the datapath.
module vpa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	output logic             out_valid,
	input  logic             out_ready,
	input  vpa_pkg::status_t stat,
	output vpa_pkg::cmd_t    cmd,
	output logic [2:0]       res_status,
	output logic             res_addr_ok
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_SPLIT = 4'd4;
	localparam logic [3:0] S_MARK  = 4'd5;
	localparam logic [3:0] S_MERGE = 4'd6;
	localparam logic [3:0] S_SCLR  = 4'd7;
	localparam logic [3:0] S_STAT  = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;
	localparam logic [3:0] S_FREE0 = 4'd10;
	localparam logic [3:0] S_SPL0  = 4'd11;

	logic [3:0] state_q;
	logic [2:0] st_q;
	logic       kind_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign res_status  = st_q;
	assign res_addr_ok = (st_q == vpa_pkg::ST_OK) && (kind_q == vpa_pkg::KIND_ALLOC);

	always_comb begin
		cmd.op = vpa_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE:  cmd.op = (in_valid) ? vpa_pkg::OP_LOAD : vpa_pkg::OP_NONE;
			S_SCAN:  cmd.op = stat.scan_done ? vpa_pkg::OP_NONE : vpa_pkg::OP_SCAN;
			S_SPLIT: cmd.op = vpa_pkg::OP_SPLIT;
			S_MARK:  cmd.op = stat.scan_done ? vpa_pkg::OP_NONE : vpa_pkg::OP_MARK;
			S_FREE0: cmd.op = vpa_pkg::OP_STAT_CLR;
			S_MERGE: cmd.op = vpa_pkg::OP_MERGE;
			S_SCLR:  cmd.op = vpa_pkg::OP_STAT_CLR;
			S_STAT:  cmd.op = vpa_pkg::OP_STAT;
			default: cmd.op = vpa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= vpa_pkg::ST_OK;
			kind_q  <= vpa_pkg::KIND_ALLOC;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					kind_q  <= kind;
					st_q    <= vpa_pkg::ST_OK;
					state_q <= (kind == vpa_pkg::KIND_ALLOC) ? S_CHECK : S_MARK;
				end
				S_CHECK: begin
					if (stat.bad_size) begin
						st_q    <= vpa_pkg::ST_BAD_SIZE;
						state_q <= S_SCLR;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: if (stat.scan_done) state_q <= S_DEC;
				S_DEC: begin
					if (!stat.sel_found) begin
						st_q    <= vpa_pkg::ST_NO_FIT;
						state_q <= S_SCLR;
					end else if (stat.need_split && stat.table_full) begin
						st_q    <= vpa_pkg::ST_FULL;
						state_q <= S_SCLR;
					end else if (stat.need_split) begin
						state_q <= S_SPL0;
					end else begin
						state_q <= S_SPLIT;
					end
				end
				// The scan leaves the index at the entry count, the first slot above the table.
				S_SPL0: state_q <= S_SPLIT;
				S_SPLIT: if (stat.shift_done) state_q <= S_SCLR;
				S_MARK: if (stat.scan_done) begin
					if (stat.pid_found) begin
						state_q <= S_FREE0;
					end else begin
						st_q    <= vpa_pkg::ST_NO_PID;
						state_q <= S_SCLR;
					end
				end
				S_FREE0: state_q <= S_MERGE;
				S_MERGE: if (stat.shift_done) state_q <= S_SCLR;
				S_SCLR:  state_q <= S_STAT;
				S_STAT:  if (stat.scan_done) state_q <= S_OUT;
				S_OUT:   if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
